// File: sv/amrp_pkg.sv
// ----------------------------------------------------------------------------
// amrp_pkg: shared definitions for the ASCII meter response parser
// Field widths, frame layout constants, status codes and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package amrp_pkg;

   // Default values for the top-level parameters
   localparam int DATA_CHARS_DEF      = 8;
   localparam int FRACTION_DIGITS_DEF = 4;

   // Field and state widths
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int MEASURE_W = 40;
   localparam int ACC_W     = 27;
   localparam int DEC_W     = 3;
   localparam int POW_W     = 20;   // holds 10^6, the largest fill-in scale
   localparam int PROD_W    = ACC_W + POW_W;

   // Frame ids and layout
   localparam logic [BYTE_W-1:0] ID_ANSWER       = 8'd37;
   localparam logic [BYTE_W-1:0] ID_ERROR        = 8'd38;
   localparam logic [BYTE_W-1:0] CODE_OFFSET     = 8'd32;
   localparam logic [BYTE_W-1:0] MIN_LEN         = 8'd10;
   localparam logic [BYTE_W-1:0] ANSWER_LEN      = 8'd18;
   localparam logic [BYTE_W-1:0] ID_POS          = 8'd1;
   localparam logic [BYTE_W-1:0] REG_POS         = 8'd5;
   localparam logic [BYTE_W-1:0] SHORT_CHECK_POS = 8'd6;
   localparam logic [BYTE_W-1:0] LONG_CHECK_POS  = 8'd16;
   localparam logic [BYTE_W-1:0] DATA_POS        = 8'd8;
   localparam logic [BYTE_W-1:0] COUNT_MAX       = 8'd255;

   // ASCII characters seen in the data field
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   localparam logic [MEASURE_W-1:0] MEASURE_MAX = {MEASURE_W{1'b1}};

   // Per-frame status
   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_BAD_LEN      = 3'd1,
      ST_ERROR_FRAME  = 3'd2,
      ST_ERROR_CHECK  = 3'd3,
      ST_ANSWER_CHECK = 3'd4,
      ST_OTHER_ID     = 3'd5
   } status_type;

   // Expected check byte for a running XOR
   function automatic logic [BYTE_W-1:0] check_of(input logic [BYTE_W-1:0] x);
      return (x < CODE_OFFSET) ? ~x : x;
   endfunction

   // Power of ten used to fill in missing fraction digits
   function automatic logic [POW_W-1:0] pow10(input logic [DEC_W-1:0] k);
      logic [POW_W-1:0] p;
      case (k)
         3'd0: p = 20'd1;
         3'd1: p = 20'd10;
         3'd2: p = 20'd100;
         3'd3: p = 20'd1000;
         3'd4: p = 20'd10000;
         3'd5: p = 20'd100000;
         3'd6: p = 20'd1000000;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// File: sv/amrp_req_if.sv
// ----------------------------------------------------------------------------
// amrp_req_if: received byte channel
// One frame byte per item, with the end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface amrp_req_if
   import amrp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: sv/amrp_rsp_if.sv
// ----------------------------------------------------------------------------
// amrp_rsp_if: frame status channel
// One item per frame: status and the kept register, measure and answer flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface amrp_rsp_if
   import amrp_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [BYTE_W-1:0]    register_word;
   logic [MEASURE_W-1:0] measure;
   logic                 answer_received;

   modport source (output valid, output status, output register_word,
                   output measure, output answer_received, input ready);
   modport sink   (input valid, input status, input register_word,
                   input measure, input answer_received, output ready);
endinterface

`default_nettype wire

// File: sv/amrp_csr_if.sv
// ----------------------------------------------------------------------------
// amrp_csr_if: configuration write channel
// Carries the display register number.
// ----------------------------------------------------------------------------
`default_nettype none

interface amrp_csr_if
   import amrp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] display_register;

   modport source (output valid, output display_register, input ready);
   modport sink   (input valid, input display_register, output ready);
endinterface

`default_nettype wire

// File: sv/ascii_meter_response_parser.sv
// ----------------------------------------------------------------------------
// ascii_meter_response_parser: meter response frame checker and decoder
// Checks length, id and check byte of each frame, keeps the register number
// and converts the display register's ASCII data into a fixed-point value.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch  : one frame byte per item, starting at STX; frame_end marks the
//            last byte. Taken at a clock edge with valid and ready high.
//  rsp_ch  : one item per frame: status, register_word, measure and
//            answer_received, shown after the frame's last byte.
//  csr_ch  : display_register write; always ready, write only while idle.
// Throughput: one byte per cycle while no frame end is held back by a
//  pending result. Every byte goes through one input register, then the
//  per-byte XOR, compares and multiply-by-ten accumulate update the frame
//  state from that register.
// Result: registered as the frame end leaves the input register.
//  The measure scaling multiply reads the frame state directly and lands in
//  the kept-value registers together with the result.
// Stall: while a result waits, bytes of the next frame keep flowing; only
//  a further frame end waits in the input register, and req_ch.ready drops
//  until the pending result is taken.
// Reset: clears the frame state, kept values, display register and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_meter_response_parser
   import amrp_pkg::*;
#(
   parameter int DATA_CHARS      = DATA_CHARS_DEF,
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   amrp_req_if.sink   req_ch,
   amrp_rsp_if.source rsp_ch,
   amrp_csr_if.sink   csr_ch
);

   localparam logic [BYTE_W-1:0] DATA_END = BYTE_W'(int'(DATA_POS) + DATA_CHARS);
   localparam logic [DEC_W-1:0]  FRAC     = DEC_W'(FRACTION_DIGITS);

   // Input register
   logic              stage_valid_ff;
   logic [BYTE_W-1:0] stage_byte_ff;
   logic              stage_end_ff;
   logic              advance;

   // Configuration
   logic [BYTE_W-1:0] display_register_ff;

   // Per-frame state
   logic [BYTE_W-1:0] byte_count_ff,    byte_count_in;
   logic [BYTE_W-1:0] running_xor_ff,   running_xor_in;
   logic [BYTE_W-1:0] frame_id_ff,      frame_id_in;
   logic [BYTE_W-1:0] register_byte_ff, register_byte_in;
   logic              short_ok_ff,      short_ok_in;
   logic              long_ok_ff,       long_ok_in;
   logic [ACC_W-1:0]  acc_ff,           acc_in;
   logic [DEC_W-1:0]  dec_ff,           dec_in;
   logic              dot_ff,           dot_in;
   logic              stopped_ff,       stopped_in;

   // Kept values and result register
   logic [BYTE_W-1:0]    last_register_ff, last_register_in;
   logic [MEASURE_W-1:0] last_measure_ff,  last_measure_in;
   logic                 answer_flag_ff,   answer_flag_in;
   status_type           status_ff,        status_in;
   logic                 rsp_valid_ff;

   // Helpers
   logic [BYTE_W-1:0]  pos;
   logic               in_window;
   logic               is_digit;
   logic               is_sign;
   logic [3:0]         digit_byte;
   logic [ACC_W-1:0]   acc_x10;
   logic [DEC_W-1:0]   scale;
   logic [PROD_W-1:0]  product;
   logic [MEASURE_W-1:0] scaled;
   logic [BYTE_W-1:0]  register_new;

   // Handshakes: a frame end waits only while a result is still pending
   assign advance      = stage_valid_ff && (!stage_end_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !stage_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         stage_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         stage_byte_ff <= req_ch.rx_byte;
         stage_end_ff  <= req_ch.frame_end;
      end
   end

   // Display register write
   always_ff @(posedge clock) begin
      if (reset) begin
         display_register_ff <= '0;
      end else if (csr_ch.valid) begin
         display_register_ff <= csr_ch.display_register;
      end
   end

   // Per-byte frame update
   assign pos        = byte_count_ff;
   assign in_window  = (pos >= DATA_POS) && (pos < DATA_END);
   assign is_digit   = (stage_byte_ff >= CH_ZERO) && (stage_byte_ff <= CH_NINE);
   assign is_sign    = (pos == DATA_POS) &&
                       ((stage_byte_ff == CH_PLUS) || (stage_byte_ff == CH_MINUS));
   assign digit_byte = stage_byte_ff[3:0];   // low nibble of an ASCII digit
   assign acc_x10    = {acc_ff[ACC_W-4:0], 3'b000} + {acc_ff[ACC_W-2:0], 1'b0};

   always_comb begin
      frame_id_in      = frame_id_ff;
      register_byte_in = register_byte_ff;
      short_ok_in      = short_ok_ff;
      long_ok_in       = long_ok_ff;
      running_xor_in   = running_xor_ff;
      acc_in           = acc_ff;
      dec_in           = dec_ff;
      dot_in           = dot_ff;
      stopped_in       = stopped_ff;
      byte_count_in    = (byte_count_ff == COUNT_MAX) ? COUNT_MAX : byte_count_ff + 8'd1;

      if (pos == ID_POS) begin
         frame_id_in = stage_byte_ff;
      end
      if (pos == REG_POS) begin
         register_byte_in = stage_byte_ff;
      end
      if (pos == SHORT_CHECK_POS) begin
         short_ok_in = (check_of(running_xor_ff) == stage_byte_ff);
      end
      if (pos == LONG_CHECK_POS) begin
         long_ok_in = (check_of(running_xor_ff) == stage_byte_ff);
      end
      if (pos < LONG_CHECK_POS) begin
         running_xor_in = running_xor_ff ^ stage_byte_ff;
      end

      // ASCII conversion; digits past the kept fraction are dropped (truncation)
      if (in_window && !stopped_ff && !is_sign) begin
         if (is_digit) begin
            if (!(dot_ff && (dec_ff >= FRAC))) begin
               acc_in = acc_x10 + ACC_W'(digit_byte);
            end
            if (dot_ff) begin
               dec_in = dec_ff + 3'd1;
            end
         end else if ((stage_byte_ff == CH_DOT) && !dot_ff) begin
            dot_in = 1'b1;
         end else begin
            stopped_in = 1'b1;
         end
      end
   end

   // Measure scaling: fill missing fraction digits, saturate at 40 bits
   assign scale   = (dec_ff < FRAC) ? (FRAC - dec_ff) : '0;
   assign product = PROD_W'(acc_ff) * PROD_W'(pow10(scale));
   assign scaled  = (product[PROD_W-1:MEASURE_W] != '0) ? MEASURE_MAX
                                                         : product[MEASURE_W-1:0];
   assign register_new = register_byte_in - CODE_OFFSET;

   // Frame status and kept values
   always_comb begin
      last_register_in = last_register_ff;
      last_measure_in  = last_measure_ff;
      answer_flag_in   = answer_flag_ff;
      status_in        = ST_OK;
      if (byte_count_in < MIN_LEN) begin
         status_in = ST_BAD_LEN;
      end else if (frame_id_in == ID_ERROR) begin
         status_in = short_ok_in ? ST_ERROR_FRAME : ST_ERROR_CHECK;
      end else if (frame_id_in == ID_ANSWER) begin
         if (byte_count_in < ANSWER_LEN) begin
            status_in = ST_BAD_LEN;
         end else if (!long_ok_in) begin
            status_in = ST_ANSWER_CHECK;
         end else begin
            status_in        = ST_OK;
            last_register_in = register_new;
            answer_flag_in   = 1'b1;
            if (register_new == display_register_ff) begin
               last_measure_in = scaled;
            end
         end
      end else begin
         status_in = ST_OTHER_ID;
      end
   end

   // Frame state registers: cleared after each frame end
   always_ff @(posedge clock) begin
      if (reset || (advance && stage_end_ff)) begin
         byte_count_ff    <= '0;
         running_xor_ff   <= '0;
         frame_id_ff      <= '0;
         register_byte_ff <= '0;
         short_ok_ff      <= 1'b0;
         long_ok_ff       <= 1'b0;
         acc_ff           <= '0;
         dec_ff           <= '0;
         dot_ff           <= 1'b0;
         stopped_ff       <= 1'b0;
      end else if (advance) begin
         byte_count_ff    <= byte_count_in;
         running_xor_ff   <= running_xor_in;
         frame_id_ff      <= frame_id_in;
         register_byte_ff <= register_byte_in;
         short_ok_ff      <= short_ok_in;
         long_ok_ff       <= long_ok_in;
         acc_ff           <= acc_in;
         dec_ff           <= dec_in;
         dot_ff           <= dot_in;
         stopped_ff       <= stopped_in;
      end
   end

   // Result register and kept values
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         status_ff        <= ST_OK;
         last_register_ff <= '0;
         last_measure_ff  <= '0;
         answer_flag_ff   <= 1'b0;
      end else if (advance && stage_end_ff) begin
         rsp_valid_ff     <= 1'b1;
         status_ff        <= status_in;
         last_register_ff <= last_register_in;
         last_measure_ff  <= last_measure_in;
         answer_flag_ff   <= answer_flag_in;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff     <= 1'b0;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.register_word   = last_register_ff;
   assign rsp_ch.measure         = last_measure_ff;
   assign rsp_ch.answer_received = answer_flag_ff;

   // Assertions
   a_ready_low_only_on_blocked_end: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (stage_valid_ff && stage_end_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("input stalled without a pending frame end");

   a_answer_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      answer_flag_ff |=> answer_flag_ff)
      else $error("answer flag dropped");

   a_ok_sets_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_OK)) |-> answer_flag_ff)
      else $error("ok status without answer flag");

   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_end_ff) |=> ((byte_count_ff == '0) && (acc_ff == '0)))
      else $error("frame state not cleared after frame end");

endmodule

`default_nettype wire

// File: tb/ascii_meter_response_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_meter_response_parser_tb: self-checking bench for the response parser
// Sends meter frames byte by byte through the request channel and compares
// every frame status item against an in-bench parser model. A short table of
// hand-built frames comes first, then random frames under several display
// register settings, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------

module ascii_meter_response_parser_tb;
   import amrp_pkg::*;

   localparam int              WATCHDOG_LIMIT = 2000;
   localparam int              HOLD_CYCLES    = 300;
   localparam int              SETTLE_CYCLES  = 6;
   localparam int              DRAIN_CYCLES   = 8;
   localparam int              RANDOM_BYTES   = 160;
   localparam int              PHASES         = 4;
   localparam int              DIRECTED_COUNT = 19;
   localparam logic [BYTE_W-1:0] STX          = 8'h02;

   // One frame to send, with optional hand-typed expectations
   typedef struct {
      logic [BYTE_W-1:0]    id;
      logic [BYTE_W-1:0]    reg_code;
      logic [63:0]          digits;
      int unsigned          len;
      bit                   corrupt;
      bit                   has_status;
      status_type           status;
      bit                   has_measure;
      logic [MEASURE_W-1:0] measure;
   } frame_plan;

   // One byte item on the request channel plus the frame's typed expectations
   typedef struct packed {
      logic [BYTE_W-1:0]    rx_byte;
      logic                 frame_end;
      logic                 has_status;
      status_type           status;
      logic                 has_measure;
      logic [MEASURE_W-1:0] measure;
   } byte_item;

   // Status item of one frame
   typedef struct packed {
      status_type           status;
      logic [BYTE_W-1:0]    register_word;
      logic [MEASURE_W-1:0] measure;
      logic                 answer_received;
   } frame_result;

   logic clock;
   logic reset;
   logic hold_rsp = 1'b0;

   amrp_req_if req_ch ();
   amrp_rsp_if rsp_ch ();
   amrp_csr_if csr_ch ();

   ascii_meter_response_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   byte_item    send_q [$];
   frame_result expected_q [$];
   byte_item    cur_tag;
   frame_plan   directed_frames [DIRECTED_COUNT];

   int mismatch_count = 0;
   int bytes_taken    = 0;
   int frames_seen    = 0;
   int results_seen   = 0;
   int idle_cycles    = 0;
   int bytes_queued   = 0;
   int status_count [6];

   // Parser model state
   logic [BYTE_W-1:0]    p_count, p_xor, p_id, p_reg;
   logic                 p_short_ok, p_long_ok, p_dot, p_stop;
   logic [ACC_W-1:0]     p_acc;
   logic [DEC_W-1:0]     p_dec;
   logic [BYTE_W-1:0]    p_display;
   logic [BYTE_W-1:0]    kept_reg;
   logic [MEASURE_W-1:0] kept_measure;
   logic                 kept_answer;

   // Check byte for a running XOR: inverted when below the code offset
   function automatic logic [BYTE_W-1:0] frame_check_for(input logic [BYTE_W-1:0] x);
      return (x < CODE_OFFSET) ? ~x : x;
   endfunction

   // Model: take one frame byte, return the frame status on the last byte
   task automatic parse_meter_byte(input logic [BYTE_W-1:0] b, input logic last,
                                   output frame_result r);
      logic [BYTE_W-1:0] pos;
      logic [63:0]       v;
      int                dec;
      status_type        st;
      pos = p_count;
      if (pos == ID_POS) p_id = b;
      if (pos == REG_POS) p_reg = b;
      if (pos == SHORT_CHECK_POS) p_short_ok = (frame_check_for(p_xor) == b);
      if (pos == LONG_CHECK_POS) p_long_ok = (frame_check_for(p_xor) == b);
      if (pos < LONG_CHECK_POS) p_xor ^= b;
      // ASCII to fixed point over the data field
      if (pos >= DATA_POS && pos < DATA_POS + DATA_CHARS_DEF && !p_stop) begin
         if (pos == DATA_POS && (b == CH_PLUS || b == CH_MINUS)) begin
         end else if (b >= CH_ZERO && b <= CH_NINE) begin
            p_acc = p_acc * 27'd10 + 27'(b - CH_ZERO);
            if (p_dot) p_dec = p_dec + 3'd1;
         end else if (b == CH_DOT && !p_dot) begin
            p_dot = 1'b1;
         end else begin
            p_stop = 1'b1;
         end
      end
      if (p_count != COUNT_MAX) p_count = p_count + 8'd1;
      r = '0;
      if (last) begin
         if (p_count < MIN_LEN) st = ST_BAD_LEN;
         else if (p_id == ID_ERROR) st = p_short_ok ? ST_ERROR_FRAME : ST_ERROR_CHECK;
         else if (p_id == ID_ANSWER) begin
            if (p_count < ANSWER_LEN) st = ST_BAD_LEN;
            else if (!p_long_ok) st = ST_ANSWER_CHECK;
            else begin
               st = ST_OK;
               kept_reg = p_reg - CODE_OFFSET;
               if (kept_reg == p_display) begin
                  // fill missing fraction digits, truncate extra ones
                  v = 64'(p_acc);
                  dec = int'(p_dec);
                  while (dec < FRACTION_DIGITS_DEF) begin
                     v = v * 64'd10;
                     if (v > 64'(MEASURE_MAX)) v = 64'(MEASURE_MAX) + 64'd1;
                     dec++;
                  end
                  while (dec > FRACTION_DIGITS_DEF) begin
                     v = v / 64'd10;
                     dec--;
                  end
                  if (v > 64'(MEASURE_MAX)) v = 64'(MEASURE_MAX);
                  kept_measure = v[MEASURE_W-1:0];
               end
               kept_answer = 1'b1;
            end
         end else st = ST_OTHER_ID;
         r.status          = st;
         r.register_word   = kept_reg;
         r.measure         = kept_measure;
         r.answer_received = kept_answer;
         p_count = '0; p_xor = '0; p_id = '0; p_reg = '0;
         p_short_ok = 1'b0; p_long_ok = 1'b0; p_acc = '0; p_dec = '0;
         p_dot = 1'b0; p_stop = 1'b0;
      end
   endtask

   // Break a frame plan into byte items, computing the check byte
   task automatic queue_frame(input frame_plan f);
      logic [BYTE_W-1:0] run_xor;
      logic [BYTE_W-1:0] fb;
      byte_item          it;
      int                i;
      run_xor = '0;
      for (i = 0; i < int'(f.len); i++) begin
         if (i == 0) fb = STX;
         else if (i == ID_POS) fb = f.id;
         else if (i == REG_POS) fb = f.reg_code;
         else if (i >= DATA_POS && i < DATA_POS + DATA_CHARS_DEF)
            fb = f.digits[63 - 8*(i - DATA_POS) -: 8];
         else if ($urandom_range(0, 3) == 0) fb = 8'($urandom);
         else fb = 8'($urandom_range(8'h30, 8'h46));
         if ((f.id == ID_ERROR) ? (i == SHORT_CHECK_POS) : (i == LONG_CHECK_POS)) begin
            fb = frame_check_for(run_xor);
            if (f.corrupt) fb ^= 8'h01 << $urandom_range(0, 7);
         end
         if (i < LONG_CHECK_POS) run_xor ^= fb;
         it.rx_byte     = fb;
         it.frame_end   = (i == int'(f.len) - 1);
         it.has_status  = f.has_status;
         it.status      = f.status;
         it.has_measure = f.has_measure;
         it.measure     = f.measure;
         send_q.push_back(it);
      end
      bytes_queued += int'(f.len);
   endtask

   // Wait until every byte is taken and every status item has come back
   task automatic wait_idle();
      do @(posedge clock);
      while (send_q.size() != 0 || req_ch.valid || expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of random length, random gaps between them
   int burst_left = 0;
   int gap_left   = 0;
   byte_item next_item;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.rx_byte   <= '0;
         req_ch.frame_end <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (send_q.size() > 0) begin
            next_item = send_q.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.rx_byte   <= next_item.rx_byte;
            req_ch.frame_end <= next_item.frame_end;
            cur_tag          <= next_item;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(0, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern changes each time the 8-bit ready_cycle counter wraps
   logic [7:0] ready_cycle = '0;
   logic [7:0] ready_mask  = 8'hFF;
   int         ready_mode  = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         ready_cycle <= ready_cycle + 8'd1;
         if (ready_cycle == 8'hFF) begin
            ready_mode = $urandom_range(0, 2);
            ready_mask = 8'($urandom) | 8'h01;
         end
         if (hold_rsp) rsp_ch.ready <= 1'b0;
         else if (ready_mode == 0) rsp_ch.ready <= 1'b1;
         else if (ready_mode == 1) rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         else rsp_ch.ready <= ready_mask[ready_cycle[2:0]];
      end
   end

   // Long receiver hold-off once the random frames are running
   initial begin
      wait (frames_seen >= 22);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Monitor: compare status items, run the model on taken bytes, watchdog
   logic        moved;
   frame_result want;
   frame_result pred;
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: status item with no frame pending: status %0d",
                        $time, rsp_ch.status);
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d (%s) actual %0d",
                           $time, want.status, want.status.name(), rsp_ch.status);
               end
               if (rsp_ch.register_word !== want.register_word) begin
                  mismatch_count++;
                  $display("%0t: register_word expected %0d actual %0d",
                           $time, want.register_word, rsp_ch.register_word);
               end
               if (rsp_ch.measure !== want.measure) begin
                  mismatch_count++;
                  $display("%0t: measure expected %0d actual %0d",
                           $time, want.measure, rsp_ch.measure);
               end
               if (rsp_ch.answer_received !== want.answer_received) begin
                  mismatch_count++;
                  $display("%0t: answer_received expected %0b actual %0b",
                           $time, want.answer_received, rsp_ch.answer_received);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            bytes_taken++;
            parse_meter_byte(req_ch.rx_byte, req_ch.frame_end, pred);
            if (req_ch.frame_end) begin
               // hand-typed expectations override the model where given
               if (cur_tag.has_status) pred.status = cur_tag.status;
               if (cur_tag.has_measure) pred.measure = cur_tag.measure;
               expected_q.push_back(pred);
               status_count[pred.status]++;
               frames_seen++;
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            moved = 1'b1;
            p_display = csr_ch.display_register;
         end
         if (moved) idle_cycles = 0;
         else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   // Stimulus
   logic [BYTE_W-1:0] settings [PHASES];
   logic [BYTE_W-1:0] cur_display;
   frame_plan         f;
   logic [BYTE_W-1:0] ch;
   int                ph, k, kind, pick, phase_start, phase_frames;
   bit                clean;
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      req_ch.frame_end = 1'b0;
      rsp_ch.ready = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.display_register = '0;
      foreach (status_count[i]) status_count[i] = 0;
      p_count = '0; p_xor = '0; p_id = '0; p_reg = '0;
      p_short_ok = 1'b0; p_long_ok = 1'b0; p_acc = '0; p_dec = '0;
      p_dot = 1'b0; p_stop = 1'b0;
      p_display = '0; kept_reg = '0; kept_measure = '0; kept_answer = 1'b0;

      // id, register code, data chars, length, corrupt check, typed status, typed measure
      directed_frames = '{
         '{ID_ERROR,  8'd32, "00000000",  10, 1'b0, 1'b1, ST_ERROR_FRAME,  1'b1, 40'd0},
         '{ID_ANSWER, 8'd32, "99999999",  18, 1'b0, 1'b1, ST_OK, 1'b1, 40'd999999990000},
         '{ID_ANSWER, 8'd32, "00000000",  18, 1'b0, 1'b1, ST_OK,           1'b1, 40'd0},
         '{ID_ANSWER, 8'd32, "12.34567",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "+0001.5x",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "-.123456",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, ".1234567",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "1.2.3456",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "1+345678",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "42      ",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd41, "55555555",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd16, "77777777",  18, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "11111111",  18, 1'b1, 1'b1, ST_ANSWER_CHECK, 1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "11111111",  17, 1'b0, 1'b1, ST_BAD_LEN,      1'b0, 40'd0},
         '{ID_ERROR,  8'd32, "00000000",  10, 1'b1, 1'b1, ST_ERROR_CHECK,  1'b0, 40'd0},
         '{ID_ERROR,  8'd32, "00000000",   9, 1'b0, 1'b1, ST_BAD_LEN,      1'b0, 40'd0},
         '{8'h41,     8'd32, "12345678",  18, 1'b0, 1'b1, ST_OTHER_ID,     1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "31415926",   1, 1'b0, 1'b1, ST_BAD_LEN,      1'b0, 40'd0},
         '{ID_ANSWER, 8'd32, "8.000000",  20, 1'b0, 1'b0, ST_OK,           1'b0, 40'd0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed frames run on the reset value of the display register
      for (k = 0; k < DIRECTED_COUNT; k++) queue_frame(directed_frames[k]);

      settings[0] = 8'hFF;
      settings[1] = 8'h00;
      settings[2] = 8'($urandom);
      settings[3] = 8'($urandom);
      for (ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         cur_display = settings[ph];
         @(posedge clock);
         csr_ch.valid <= 1'b1;
         csr_ch.display_register <= cur_display;
         do @(posedge clock); while (!csr_ch.ready);
         csr_ch.valid <= 1'b0;

         phase_start  = bytes_queued;
         phase_frames = 0;
         while (bytes_queued - phase_start < RANDOM_BYTES / PHASES || phase_frames < 3) begin
            kind = $urandom_range(0, 9);
            f.id          = ID_ANSWER;
            f.len         = ANSWER_LEN;
            f.corrupt     = 1'b0;
            f.has_status  = 1'b0;
            f.status      = ST_OK;
            f.has_measure = 1'b0;
            f.measure     = '0;
            f.reg_code    = ($urandom_range(0, 2) != 0) ? cur_display + CODE_OFFSET
                                                         : 8'($urandom);
            // data field: clean numbers or a mix with signs, dots and junk
            clean = $urandom_range(0, 1);
            for (k = 0; k < DATA_CHARS_DEF; k++) begin
               pick = $urandom_range(0, 19);
               if (clean || pick < 13) ch = 8'(CH_ZERO + $urandom_range(0, 9));
               else if (pick < 16) ch = CH_DOT;
               else if (pick == 16) ch = CH_PLUS;
               else if (pick == 17) ch = CH_MINUS;
               else ch = 8'($urandom);
               f.digits[63 - 8*k -: 8] = ch;
            end
            if (clean && $urandom_range(0, 2) != 0) begin
               k = $urandom_range(0, DATA_CHARS_DEF - 1);
               f.digits[63 - 8*k -: 8] = CH_DOT;
            end
            if (clean && $urandom_range(0, 3) == 0)
               f.digits[63 -: 8] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            case (kind)
               0: begin
                  f.id      = ID_ERROR;
                  f.len     = $urandom_range(9, 14);
                  f.corrupt = $urandom_range(0, 1);
               end
               1: begin
                  f.id      = 8'($urandom);
                  f.len     = $urandom_range(1, 24);
                  f.corrupt = $urandom_range(0, 1);
               end
               2: begin
                  pick = $urandom_range(0, 2);
                  if (pick == 0) f.corrupt = 1'b1;
                  else if (pick == 1) f.len = $urandom_range(10, 17);
                  else f.len = $urandom_range(19, 30);
               end
               default: if ($urandom_range(0, 4) == 0) f.len = $urandom_range(19, 21);
            endcase
            queue_frame(f);
            phase_frames++;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d bytes in %0d frames over %0d display settings, %0d status items.",
               bytes_taken, frames_seen, PHASES + 1, results_seen);
      $display("Status mix: ok %0d, bad length %0d, error %0d, error check %0d, ",
               status_count[ST_OK], status_count[ST_BAD_LEN], status_count[ST_ERROR_FRAME],
               status_count[ST_ERROR_CHECK],
               "answer check %0d, other id %0d",
               status_count[ST_ANSWER_CHECK], status_count[ST_OTHER_ID]);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
